// ===== rtl/core/srr_pkg.sv =====
// Shared types, register indexes and constants for the serpentine row reorder block.
package srr_pkg;

   localparam int MAX_ROW_DEFAULT = 64;

   localparam int SAMPLE_W   = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int WIDTH_W    = 7;
   localparam int TOTAL_W    = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_WIDTH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VARIABLE_ROWS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_TOTAL     = 2'd2;

   localparam logic [WIDTH_W-1:0] ROW_WIDTH_RESET = 7'd64;
   localparam logic [TOTAL_W-1:0] ROW_TOTAL_RESET = 16'd1;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_BURST = 2'b10
   } state_type;

   typedef struct packed {
      logic accept;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic odd_row;
      logic row_ends;
      logic pos_zero;
      logic ptr_zero;
   } status_type;

endpackage

// ===== rtl/core/serpentine_row_reorder.sv =====
// Top level of the serpentine row reorder block: controller plus datapath.
//
// The req channel takes one item per handshake: a 64-bit sample and a row-end
// mark that counts only when variable rows are enabled. The rsp channel gives
// result items with row_last and burst_last flags. Both use valid and ready.
// Even rows pass through: each item gives one result in the cycle after it is
// taken, and a new item is taken every cycle while the receiver keeps up.
// Items of an odd row are written into the row buffer and give no result
// until the row's last item. That item gives its own sample at once, then
// the buffer is read back in reverse, one item per cycle while the receiver
// keeps up, so a row of n items ends with a burst of n results; no input is
// taken while the buffer is read back. The row buffer's single read port
// sets that burst rate.
// The csr port writes row_width, variable_rows and row_total by index; write
// only while the block is idle.
// Reset clears the row and column counters, returns the registers to a
// width of 64, fixed rows and a total of 1, and drops any pending result.
// When the receiver stalls, the result register holds and input stops.
module serpentine_row_reorder #(
   parameter int MaxRow = srr_pkg::MAX_ROW_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [srr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [srr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [srr_pkg::SAMPLE_W-1:0]    req_sample_in,
   input  logic                            req_row_end_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [srr_pkg::SAMPLE_W-1:0]    rsp_sample_out,
   output logic                            rsp_row_last,
   output logic                            rsp_burst_last
);

   srr_pkg::cmd_type    cmd;
   srr_pkg::status_type status;

   srr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   srr_datapath #(
      .MaxRow (MaxRow)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_sample_in  (req_sample_in),
      .req_row_end_in (req_row_end_in),
      .cmd            (cmd),
      .status         (status),
      .rsp_sample_out (rsp_sample_out),
      .rsp_row_last   (rsp_row_last),
      .rsp_burst_last (rsp_burst_last)
   );

endmodule

// ===== rtl/core/srr_datapath.sv =====
// Datapath: configuration registers, row counters, odd-row buffer and result register.
module srr_datapath #(
   parameter int MaxRow = srr_pkg::MAX_ROW_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [srr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [srr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic [srr_pkg::SAMPLE_W-1:0]    req_sample_in,
   input  logic                            req_row_end_in,
   input  srr_pkg::cmd_type                cmd,
   output srr_pkg::status_type             status,
   output logic [srr_pkg::SAMPLE_W-1:0]    rsp_sample_out,
   output logic                            rsp_row_last,
   output logic                            rsp_burst_last
);

   localparam int AW = (MaxRow > 1) ? $clog2(MaxRow) : 1;

   logic [srr_pkg::WIDTH_W-1:0] row_width_ff;
   logic                        variable_rows_ff;
   logic [srr_pkg::TOTAL_W-1:0] row_total_ff;

   logic [AW-1:0]               pos_ff, pos_in;
   logic [AW-1:0]               ptr_ff, ptr_in;
   logic [srr_pkg::TOTAL_W-1:0] row_index_ff, row_index_in;

   logic [srr_pkg::SAMPLE_W-1:0] row_store [MaxRow];
   logic [srr_pkg::SAMPLE_W-1:0] rd_data_ff;
   logic [AW-1:0]                rd_addr;
   logic                         rd_en;

   logic [srr_pkg::SAMPLE_W-1:0] sample_ff, sample_in;
   logic                         row_last_ff, row_last_in;
   logic                         burst_last_ff, burst_last_in;

   logic [7:0]                   pos_plus;
   logic [7:0]                   width_eff;
   logic                         row_ends;
   logic [srr_pkg::TOTAL_W:0]    index_plus;
   logic [srr_pkg::TOTAL_W:0]    total_eff;

   always_comb begin
      pos_plus = 8'(pos_ff) + 8'd1;
      if (row_width_ff == '0) begin
         width_eff = 8'd1;
      end else if (8'(row_width_ff) > 8'(MaxRow)) begin
         width_eff = 8'(MaxRow);
      end else begin
         width_eff = 8'(row_width_ff);
      end
      if (variable_rows_ff) begin
         row_ends = req_row_end_in || (pos_plus >= 8'(MaxRow));
      end else begin
         row_ends = pos_plus >= width_eff;
      end
   end

   assign status.odd_row  = row_index_ff[0];
   assign status.row_ends = row_ends;
   assign status.pos_zero = (pos_ff == '0);
   assign status.ptr_zero = (ptr_ff == '0);

   always_comb begin
      total_eff  = (row_total_ff == '0) ? 17'd1 : {1'b0, row_total_ff};
      index_plus = {1'b0, row_index_ff} + 17'd1;
      pos_in       = pos_ff;
      row_index_in = row_index_ff;
      if (cmd.accept) begin
         if (row_ends) begin
            pos_in       = '0;
            row_index_in = (index_plus >= total_eff) ? '0 : index_plus[srr_pkg::TOTAL_W-1:0];
         end else begin
            pos_in = pos_ff + AW'(1);
         end
      end
   end

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = ptr_ff - AW'(1);
      ptr_in  = ptr_ff;
      if (cmd.accept && row_index_ff[0] && row_ends && (pos_ff != '0)) begin
         rd_en   = 1'b1;
         rd_addr = pos_ff - AW'(1);
         ptr_in  = pos_ff - AW'(1);
      end else if (cmd.step && (ptr_ff != '0)) begin
         rd_en  = 1'b1;
         ptr_in = ptr_ff - AW'(1);
      end
   end

   always_comb begin
      sample_in     = sample_ff;
      row_last_in   = row_last_ff;
      burst_last_in = burst_last_ff;
      if (cmd.accept) begin
         sample_in = req_sample_in;
         if (row_index_ff[0]) begin
            row_last_in   = (pos_ff == '0);
            burst_last_in = (pos_ff == '0);
         end else begin
            row_last_in   = row_ends;
            burst_last_in = 1'b1;
         end
      end else if (cmd.step) begin
         sample_in     = rd_data_ff;
         row_last_in   = (ptr_ff == '0);
         burst_last_in = (ptr_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff     <= srr_pkg::ROW_WIDTH_RESET;
         variable_rows_ff <= 1'b0;
         row_total_ff     <= srr_pkg::ROW_TOTAL_RESET;
         pos_ff           <= '0;
         row_index_ff     <= '0;
         ptr_ff           <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               srr_pkg::CSR_ROW_WIDTH: begin
                  row_width_ff <= csr_wdata[srr_pkg::WIDTH_W-1:0];
               end
               srr_pkg::CSR_VARIABLE_ROWS: begin
                  variable_rows_ff <= csr_wdata[0];
               end
               srr_pkg::CSR_ROW_TOTAL: begin
                  row_total_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
         pos_ff       <= pos_in;
         row_index_ff <= row_index_in;
         ptr_ff       <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && row_index_ff[0]) begin
         row_store[pos_ff] <= req_sample_in;
      end
      if (rd_en) begin
         rd_data_ff <= row_store[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      row_last_ff   <= row_last_in;
      burst_last_ff <= burst_last_in;
   end

   assign rsp_sample_out = sample_ff;
   assign rsp_row_last   = row_last_ff;
   assign rsp_burst_last = burst_last_ff;

endmodule

// ===== rtl/core/srr_controller.sv =====
// Controller: accepts items, sequences reversed bursts and owns the result valid flag.
module srr_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  srr_pkg::status_type  status,
   output srr_pkg::cmd_type     cmd
);

   srr_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == srr_pkg::ST_IDLE) && out_free;
   assign cmd.accept = req_valid && req_ready;
   assign cmd.step   = (state_ff == srr_pkg::ST_BURST) && out_free;
   assign rsp_valid  = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         srr_pkg::ST_IDLE: begin
            if (cmd.accept) begin
               if (!status.odd_row || status.row_ends) begin
                  rsp_valid_in = 1'b1;
               end
               if (status.odd_row && status.row_ends && !status.pos_zero) begin
                  state_in = srr_pkg::ST_BURST;
               end
            end
         end
         srr_pkg::ST_BURST: begin
            if (cmd.step) begin
               rsp_valid_in = 1'b1;
               if (status.ptr_zero) begin
                  state_in = srr_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = srr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_burst_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (state_ff == srr_pkg::ST_BURST) |-> !req_ready)
      else $error("input taken during a burst");

   a_burst_has_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == srr_pkg::ST_BURST) |-> rsp_valid_ff)
      else $error("burst without a pending result");

   a_burst_entry: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && status.odd_row && status.row_ends && !status.pos_zero)
      |=> (state_ff == srr_pkg::ST_BURST))
      else $error("odd row end did not start a burst");

   a_burst_exit: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && status.ptr_zero) |=> (state_ff == srr_pkg::ST_IDLE))
      else $error("burst did not end after its last item");

endmodule

// ===== tb/sv/serpentine_row_reorder_tb.sv =====
// Self-checking testbench for the serpentine row reorder block.
module serpentine_row_reorder_tb;

   localparam int MAX_ROW = srr_pkg::MAX_ROW_DEFAULT;
   localparam int RANDOM_ITEMS = 360;
   localparam int CALM_TAIL = 50;
   localparam int DRAIN_CYCLES = 8;
   localparam int STALL_LIMIT = 2000;
   localparam logic [srr_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [srr_pkg::SAMPLE_W-1:0] sample;
      logic                         row_last;
      logic                         burst_last;
   } reorder_result_type;

   typedef enum logic {
      KIND_CSR,
      KIND_ITEM
   } step_kind_type;

   typedef struct packed {
      step_kind_type                kind;
      logic [1:0]                   reg_index;
      logic [srr_pkg::SAMPLE_W-1:0] value;
      logic                         mark;
      logic                         known;
      logic [srr_pkg::SAMPLE_W-1:0] want_sample;
      logic                         want_row_last;
      logic                         want_burst_last;
   } plan_row_type;

   localparam int PLAN_LEN = 27;
   localparam plan_row_type PLAN [PLAN_LEN] = '{
      '{KIND_ITEM, 2'd0, 64'd0, 1'b0, 1'b1, 64'd0, 1'b0, 1'b1},
      '{KIND_ITEM, 2'd0, {64{1'b1}}, 1'b1, 1'b1, {64{1'b1}}, 1'b0, 1'b1},
      '{KIND_CSR, srr_pkg::CSR_ROW_WIDTH, 64'd0, 1'b0, 1'b0, 64'd0, 1'b0, 1'b0},
      '{KIND_CSR, srr_pkg::CSR_ROW_TOTAL, 64'd2, 1'b0, 1'b0, 64'd0, 1'b0, 1'b0},
      '{KIND_ITEM, 2'd0, 64'h0123_4567_89ab_cdef, 1'b0, 1'b1,
        64'h0123_4567_89ab_cdef, 1'b1, 1'b1},
      '{KIND_ITEM, 2'd0, 64'hfedc_ba98_7654_3210, 1'b0, 1'b1,
        64'hfedc_ba98_7654_3210, 1'b1, 1'b1},
      '{KIND_CSR, srr_pkg::CSR_ROW_WIDTH, 64'hff83, 1'b0, 1'b0, 64'd0, 1'b0, 1'b0},
      '{KIND_ITEM, 2'd0, 64'h8000_0000_0000_0001, 1'b0, 1'b1,
        64'h8000_0000_0000_0001, 1'b0, 1'b1},
      '{KIND_ITEM, 2'd0, 64'h7fff_ffff_ffff_fffe, 1'b0, 1'b1,
        64'h7fff_ffff_ffff_fffe, 1'b0, 1'b1},
      '{KIND_ITEM, 2'd0, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, 1'b1,
        64'haaaa_aaaa_aaaa_aaaa, 1'b1, 1'b1},
      '{KIND_ITEM, 2'd0, 64'h5555_5555_5555_5555, 1'b0, 1'b0, 64'd0, 1'b0, 1'b0},
      '{KIND_ITEM, 2'd0, 64'h0f0f_0f0f_0f0f_0f0f, 1'b1, 1'b0, 64'd0, 1'b0, 1'b0},
      '{KIND_ITEM, 2'd0, 64'hf0f0_f0f0_f0f0_f0f0, 1'b0, 1'b0, 64'd0, 1'b0, 1'b0},
      '{KIND_CSR, srr_pkg::CSR_ROW_WIDTH, 64'd127, 1'b0, 1'b0, 64'd0, 1'b0, 1'b0},
      '{KIND_CSR, srr_pkg::CSR_VARIABLE_ROWS, 64'hffff, 1'b0, 1'b0, 64'd0, 1'b0, 1'b0},
      '{KIND_CSR, srr_pkg::CSR_ROW_TOTAL, 64'hffff, 1'b0, 1'b0, 64'd0, 1'b0, 1'b0},
      '{KIND_ITEM, 2'd0, 64'd1, 1'b1, 1'b1, 64'd1, 1'b1, 1'b1},
      '{KIND_ITEM, 2'd0, 64'd2, 1'b0, 1'b0, 64'd0, 1'b0, 1'b0},
      '{KIND_ITEM, 2'd0, 64'd3, 1'b1, 1'b0, 64'd0, 1'b0, 1'b0},
      '{KIND_CSR, CSR_UNUSED, 64'hffff, 1'b0, 1'b0, 64'd0, 1'b0, 1'b0},
      '{KIND_ITEM, 2'd0, 64'd4, 1'b0, 1'b1, 64'd4, 1'b0, 1'b1},
      '{KIND_ITEM, 2'd0, 64'd5, 1'b1, 1'b1, 64'd5, 1'b1, 1'b1},
      '{KIND_ITEM, 2'd0, 64'd6, 1'b1, 1'b1, 64'd6, 1'b1, 1'b1},
      '{KIND_CSR, srr_pkg::CSR_ROW_TOTAL, 64'd2, 1'b0, 1'b0, 64'd0, 1'b0, 1'b0},
      '{KIND_ITEM, 2'd0, 64'd7, 1'b1, 1'b1, 64'd7, 1'b1, 1'b1},
      '{KIND_ITEM, 2'd0, 64'd8, 1'b0, 1'b1, 64'd8, 1'b0, 1'b1},
      '{KIND_ITEM, 2'd0, 64'd9, 1'b1, 1'b1, 64'd9, 1'b1, 1'b1}
   };

   logic                           clock;
   logic                           reset;
   logic                           csr_we;
   logic [srr_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [srr_pkg::CSR_DATA_W-1:0] csr_wdata;
   logic                           req_valid;
   logic                           req_ready;
   logic [srr_pkg::SAMPLE_W-1:0]   req_sample_in;
   logic                           req_row_end_in;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [srr_pkg::SAMPLE_W-1:0]   rsp_sample_out;
   logic                           rsp_row_last;
   logic                           rsp_burst_last;

   logic [srr_pkg::WIDTH_W-1:0]  width_reg = srr_pkg::ROW_WIDTH_RESET;
   logic                         variable_reg = 1'b0;
   logic [srr_pkg::TOTAL_W-1:0]  total_reg = srr_pkg::ROW_TOTAL_RESET;
   int                           column_count = 0;
   logic [srr_pkg::TOTAL_W-1:0]  row_index = '0;
   logic [srr_pkg::SAMPLE_W-1:0] row_store [MAX_ROW];

   reorder_result_type expected_results [$];
   int                 errors = 0;
   logic               idle_on = 1'b0;
   int                 ready_hold = 0;
   int                 quiet_cycles = 0;

   serpentine_row_reorder uut (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .req_row_end_in (req_row_end_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_row_last   (rsp_row_last),
      .rsp_burst_last (rsp_burst_last)
   );

   always #5 clock = ~clock;

   task automatic predict_item(input logic [srr_pkg::SAMPLE_W-1:0] sample, input logic mark);
      int   pos;
      int   lim;
      int   total;
      logic ends;
      pos = (column_count >= MAX_ROW) ? MAX_ROW - 1 : column_count;
      lim = (width_reg == 0) ? 1 : ((width_reg > MAX_ROW) ? MAX_ROW : int'(width_reg));
      ends = variable_reg ? (mark || (pos + 1 >= MAX_ROW)) : (pos + 1 >= lim);
      if (!row_index[0]) begin
         expected_results.push_back(reorder_result_type'{sample, ends, 1'b1});
      end else begin
         row_store[pos] = sample;
         if (ends) begin
            for (int k = pos; k >= 0; k--) begin
               expected_results.push_back(reorder_result_type'{row_store[k], k == 0, k == 0});
            end
         end
      end
      if (ends) begin
         total = (total_reg == 0) ? 1 : int'(total_reg);
         row_index = (int'(row_index) + 1 >= total) ? '0 : row_index + 1'b1;
         column_count = 0;
      end else begin
         column_count = pos + 1;
      end
   endtask

   task automatic write_reg(input logic [srr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [srr_pkg::CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         srr_pkg::CSR_ROW_WIDTH: width_reg = data[srr_pkg::WIDTH_W-1:0];
         srr_pkg::CSR_VARIABLE_ROWS: variable_reg = data[0];
         srr_pkg::CSR_ROW_TOTAL: total_reg = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_item(input logic [srr_pkg::SAMPLE_W-1:0] sample, input logic mark);
      csr_we <= 1'b0;
      req_valid <= 1'b1;
      req_sample_in <= sample;
      req_row_end_in <= mark;
      do @(posedge clock); while (!req_ready);
      predict_item(sample, mark);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (idle_on && ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < 20) begin
         ready_hold <= $urandom_range(1, 12) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : result_check
      reorder_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected item sample_out %h", $time, rsp_sample_out);
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_sample_out !== want.sample) begin
               $display("%0t: sample_out expected %h actual %h", $time, want.sample,
                        rsp_sample_out);
               errors++;
            end
            if (rsp_row_last !== want.row_last) begin
               $display("%0t: row_last expected %b actual %b", $time, want.row_last,
                        rsp_row_last);
               errors++;
            end
            if (rsp_burst_last !== want.burst_last) begin
               $display("%0t: burst_last expected %b actual %b", $time, want.burst_last,
                        rsp_burst_last);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("FAIL serpentine_row_reorder");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int                            sent;
      int                            count;
      int                            mark_pct;
      int                            phase;
      logic                          idle_pick;
      logic [srr_pkg::WIDTH_W-1:0]   width_pick;
      logic [srr_pkg::TOTAL_W-1:0]   total_pick;
      logic [srr_pkg::SAMPLE_W-1:0]  sample;
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_sample_in = '0;
      req_row_end_in = 1'b0;
      rsp_ready = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PLAN_LEN; i++) begin
         if (PLAN[i].kind == KIND_CSR) begin
            if (i > 0 && PLAN[i-1].kind == KIND_ITEM) settle();
            write_reg(PLAN[i].reg_index, PLAN[i].value[srr_pkg::CSR_DATA_W-1:0]);
         end else begin
            send_item(PLAN[i].value, PLAN[i].mark);
            if (PLAN[i].known) begin
               void'(expected_results.pop_back());
               expected_results.push_back(reorder_result_type'{PLAN[i].want_sample,
                  PLAN[i].want_row_last, PLAN[i].want_burst_last});
            end
         end
      end

      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         settle();
         if (phase == 0) begin
            // Unmarked rows in variable mode: one even and one odd row of full length.
            write_reg(srr_pkg::CSR_ROW_WIDTH, {9'($urandom), 7'($urandom_range(1, 127))});
            write_reg(srr_pkg::CSR_VARIABLE_ROWS, 16'd1);
            write_reg(srr_pkg::CSR_ROW_TOTAL, 16'd2);
            mark_pct = 0;
            count = 2 * MAX_ROW;
         end else begin
            case ($urandom_range(0, 7))
               0: width_pick = 7'd0;
               1: width_pick = 7'd1;
               2: width_pick = 7'd64;
               3: width_pick = 7'd127;
               default: width_pick = 7'($urandom_range(2, 12));
            endcase
            case ($urandom_range(0, 7))
               0: total_pick = 16'd0;
               1: total_pick = 16'd1;
               2: total_pick = 16'd2;
               3: total_pick = 16'hffff;
               default: total_pick = 16'($urandom_range(3, 9));
            endcase
            case ($urandom_range(0, 3))
               0: mark_pct = 3;
               1: mark_pct = 15;
               2: mark_pct = 40;
               default: mark_pct = 70;
            endcase
            write_reg(srr_pkg::CSR_ROW_WIDTH, {9'($urandom), width_pick});
            write_reg(srr_pkg::CSR_VARIABLE_ROWS, 16'($urandom));
            write_reg(srr_pkg::CSR_ROW_TOTAL, total_pick);
            count = $urandom_range(8, 40);
         end
         idle_pick = (sent + count < RANDOM_ITEMS - CALM_TAIL) ? ($urandom_range(0, 3) != 0)
                                                               : 1'b0;
         idle_on <= idle_pick;
         for (int i = 0; i < count; i++) begin
            if (idle_pick && $urandom_range(0, 99) < 20) begin
               csr_we <= 1'b0;
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 12)) @(posedge clock);
            end
            case ($urandom_range(0, 9))
               0: sample = '0;
               1: sample = '1;
               default: sample = {$urandom, $urandom};
            endcase
            send_item(sample, $urandom_range(0, 99) < mark_pct);
            sent++;
         end
         phase++;
      end

      settle();
      if (errors == 0) begin
         $display("PASS serpentine_row_reorder");
      end else begin
         $display("FAIL serpentine_row_reorder");
      end
      $finish;
   end

endmodule

// ===== serpentine_row_reorder.f =====
rtl/core/srr_pkg.sv
rtl/core/srr_datapath.sv
rtl/core/srr_controller.sv
rtl/core/serpentine_row_reorder.sv
tb/sv/serpentine_row_reorder_tb.sv
